FILE: rtl/core/dahdsr_pkg.sv
// Shared types and constants of the DAHDSR envelope generator.
// Field widths, register indexes, reset values, sequencer states, state entry.
// No dependencies.
`timescale 1ns / 1ps

package dahdsr_pkg;

    localparam int CH_W      = 3;
    localparam int TIME_W    = 31;
    localparam int MAG_W     = 30;
    localparam int TICK_W    = 24;
    localparam int LVL_W     = 16;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = LVL_W + TICK_W;
    localparam int DIV_STEPS = LVL_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [MAG_W-1:0] TIME_MAX  = {MAG_W{1'b1}};
    localparam logic [LVL_W-1:0] SIGN_FLIP = {1'b1, {(LVL_W-1){1'b0}}};

    localparam logic [2:0] REG_DELAY       = 3'd0;
    localparam logic [2:0] REG_ATTACK      = 3'd1;
    localparam logic [2:0] REG_HOLD        = 3'd2;
    localparam logic [2:0] REG_DECAY       = 3'd3;
    localparam logic [2:0] REG_RELEASE     = 3'd4;
    localparam logic [2:0] REG_HOLD_LVL    = 3'd5;
    localparam logic [2:0] REG_SUSTAIN_LVL = 3'd6;

    localparam logic [TICK_W-1:0] RST_DELAY       = 24'd0;
    localparam logic [TICK_W-1:0] RST_ATTACK      = 24'd4800;
    localparam logic [TICK_W-1:0] RST_HOLD        = 24'd4800;
    localparam logic [TICK_W-1:0] RST_DECAY       = 24'd4800;
    localparam logic [TICK_W-1:0] RST_RELEASE     = 24'd4800;
    localparam logic [LVL_W-1:0]  RST_HOLD_LVL    = 16'd65535;
    localparam logic [LVL_W-1:0]  RST_SUSTAIN_LVL = 16'd49152;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DELAY,
        ST_ATTACK,
        ST_HOLD,
        ST_DECAY,
        ST_REL,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } state_t;

    // Per-channel state; level is kept unipolar (0..65535).
    typedef struct packed {
        logic             releasing;
        logic [LVL_W-1:0] level;
        logic [MAG_W-1:0] start;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: rtl/core/dahdsr_if.sv
// Valid/ready channel interfaces for note samples in and envelope levels out.
// Depends on dahdsr_pkg.
`timescale 1ns / 1ps

interface dahdsr_note_if import dahdsr_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [CH_W-1:0]          channel;
    logic signed [TIME_W-1:0] note_time;

    modport source (output valid, output channel, output note_time, input ready);
    modport sink   (input valid, input channel, input note_time, output ready);
endinterface

interface dahdsr_env_if import dahdsr_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [CH_W-1:0]         channel_out;
    logic signed [LVL_W-1:0] level;

    modport source (output valid, output channel_out, output level, input ready);
    modport sink   (input valid, input channel_out, input level, output ready);
endinterface

FILE: rtl/core/dahdsr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dahdsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/dahdsr_envelope_generator.sv
// DAHDSR envelope generator: per-channel state in one RAM, phase sequencer,
// one 16x24 multiplier and a 16-step restoring divider.
// The 16-step divider dominates interpolated phases (attack, decay, release).
// One input transaction at a time: a new one is taken only after the last result
// is in the output register.
// Reset: config registers take defaults; channel valid bits clear until written.
`timescale 1ns / 1ps

module dahdsr_envelope_generator import dahdsr_pkg::*; #(
    parameter int CHANNELS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    dahdsr_note_if.sink       note,
    dahdsr_env_if.source      env
);

    localparam int AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int XPAD = MAG_W - TICK_W;

    // configuration
    logic [TICK_W-1:0] delay_reg, attack_reg, hold_reg, decay_reg, release_reg;
    logic [LVL_W-1:0]  hold_lvl_reg, sustain_lvl_reg;
    logic              cfg_we;

    // control
    state_t            state_reg, state_next;
    logic              out_valid_reg;
    logic [CHANNELS-1:0] valid_reg;

    // datapath
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic              key_up_reg, key_up_next;
    logic [MAG_W-1:0]  t_reg, t_next;
    logic              in_range_reg, in_range_next;
    logic              rel_reg, rel_next;
    logic [LVL_W-1:0]  cap_reg, cap_next;
    logic [MAG_W-1:0]  x_reg, x_next;
    logic [LVL_W-1:0]  mul_a_reg, mul_a_next;
    logic [TICK_W-1:0] mul_b_reg, mul_b_next;
    logic [TICK_W-1:0] den_reg, den_next;
    logic [PROD_W-1:0] num_reg, num_next;
    logic [TICK_W-1:0] rem_reg, rem_next;
    logic [LVL_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [LVL_W-1:0]  base_reg, base_next;
    logic              sub_reg, sub_next;
    logic [CH_W-1:0]   out_ch_reg;
    logic [LVL_W-1:0]  out_lvl_reg;

    // combinational
    logic              accept, out_free, done_fire, ram_we;
    logic [TIME_W-1:0] raw, neg, mag;
    logic              key_up_in, in_range_in;
    logic [MAG_W-1:0]  t_in;
    logic [AW+CH_W-1:0] ch_wide_in, ch_wide_reg;
    logic [AW-1:0]     rd_addr, wr_addr;
    entry_t            rd_entry, wr_entry;
    logic              rel_hit;
    logic [MAG_W-1:0]  delay_x, attack_x, hold_x, decay_x, release_x;
    logic [PROD_W-1:0] prod;
    logic [TICK_W:0]   div_sh;
    logic [TICK_W+1:0] div_diff;
    logic              div_ge;
    logic [LVL_W-1:0]  u_final;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg       <= RST_DELAY;
            attack_reg      <= RST_ATTACK;
            hold_reg        <= RST_HOLD;
            decay_reg       <= RST_DECAY;
            release_reg     <= RST_RELEASE;
            hold_lvl_reg    <= RST_HOLD_LVL;
            sustain_lvl_reg <= RST_SUSTAIN_LVL;
        end
        else if (cfg_we)
        begin
            unique case (paddr[4:2])
                REG_DELAY:       delay_reg       <= pwdata[TICK_W-1:0];
                REG_ATTACK:      attack_reg      <= pwdata[TICK_W-1:0];
                REG_HOLD:        hold_reg        <= pwdata[TICK_W-1:0];
                REG_DECAY:       decay_reg       <= pwdata[TICK_W-1:0];
                REG_RELEASE:     release_reg     <= pwdata[TICK_W-1:0];
                REG_HOLD_LVL:    hold_lvl_reg    <= pwdata[LVL_W-1:0];
                REG_SUSTAIN_LVL: sustain_lvl_reg <= pwdata[LVL_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_DELAY:       prdata = {{(DATA_W-TICK_W){1'b0}}, delay_reg};
            REG_ATTACK:      prdata = {{(DATA_W-TICK_W){1'b0}}, attack_reg};
            REG_HOLD:        prdata = {{(DATA_W-TICK_W){1'b0}}, hold_reg};
            REG_DECAY:       prdata = {{(DATA_W-TICK_W){1'b0}}, decay_reg};
            REG_RELEASE:     prdata = {{(DATA_W-TICK_W){1'b0}}, release_reg};
            REG_HOLD_LVL:    prdata = {{(DATA_W-LVL_W){1'b0}}, hold_lvl_reg};
            REG_SUSTAIN_LVL: prdata = {{(DATA_W-LVL_W){1'b0}}, sustain_lvl_reg};
            default:         prdata = '0;
        endcase
    end

    // input decode: key-up flag, saturated time magnitude, channel range
    assign note.ready  = (state_reg == ST_IDLE) && !psel;
    assign accept      = note.valid && note.ready;
    assign raw         = $unsigned(note.note_time);
    assign key_up_in   = raw[TIME_W-1];
    assign neg         = ~raw + TIME_W'(1);
    assign mag         = key_up_in ? neg : raw;
    assign t_in        = mag[TIME_W-1] ? TIME_MAX : mag[MAG_W-1:0];
    assign in_range_in = 32'(note.channel) < CHANNELS;
    assign ch_wide_in  = {{AW{1'b0}}, note.channel};
    assign ch_wide_reg = {{AW{1'b0}}, ch_reg};
    assign rd_addr     = ch_wide_in[AW-1:0];
    assign wr_addr     = ch_wide_reg[AW-1:0];

    assign out_free  = !out_valid_reg || env.ready;
    assign done_fire = (state_reg == ST_DONE) && out_free;
    assign u_final   = sub_reg ? (base_reg - quo_reg) : (base_reg + quo_reg);

    assign wr_entry.releasing = key_up_reg;
    assign wr_entry.level     = u_final;
    assign wr_entry.start     = t_reg;
    assign ram_we = done_fire && in_range_reg && !rel_reg;

    dahdsr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rd_entry)
    );

    assign rel_hit = valid_reg[wr_addr] && rd_entry.releasing && key_up_reg;

    assign delay_x   = {{XPAD{1'b0}}, delay_reg};
    assign attack_x  = {{XPAD{1'b0}}, attack_reg};
    assign hold_x    = {{XPAD{1'b0}}, hold_reg};
    assign decay_x   = {{XPAD{1'b0}}, decay_reg};
    assign release_x = {{XPAD{1'b0}}, release_reg};

    assign prod     = mul_a_reg * mul_b_reg;
    assign div_sh   = {rem_reg, num_reg[DIV_STEPS-1]};
    assign div_diff = {1'b0, div_sh} - {2'b00, den_reg};
    assign div_ge   = !div_diff[TICK_W+1];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (!in_range_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (rel_hit)
                begin
                    state_next = ST_REL;
                end
                else
                begin
                    state_next = ST_DELAY;
                end
            end
            ST_DELAY:  state_next = (x_reg < delay_x)   ? ST_DONE : ST_ATTACK;
            ST_ATTACK: state_next = (x_reg < attack_x)  ? ST_MUL  : ST_HOLD;
            ST_HOLD:   state_next = (x_reg < hold_x)    ? ST_DONE : ST_DECAY;
            ST_DECAY:  state_next = (x_reg < decay_x)   ? ST_MUL  : ST_DONE;
            ST_REL:    state_next = (x_reg < release_x) ? ST_MUL  : ST_DONE;
            ST_MUL:    state_next = ST_PREP;
            ST_PREP:   state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        ch_next       = ch_reg;
        key_up_next   = key_up_reg;
        t_next        = t_reg;
        in_range_next = in_range_reg;
        rel_next      = rel_reg;
        cap_next      = cap_reg;
        x_next        = x_reg;
        mul_a_next    = mul_a_reg;
        mul_b_next    = mul_b_reg;
        den_next      = den_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;
        base_next     = base_reg;
        sub_next      = sub_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ch_next       = note.channel;
                    key_up_next   = key_up_in;
                    t_next        = t_in;
                    in_range_next = in_range_in;
                end
            end
            ST_READ:
            begin
                rel_next  = rel_hit;
                cap_next  = rd_entry.level;
                base_next = '0;
                sub_next  = 1'b0;
                quo_next  = '0;
                if (rel_hit)
                begin
                    x_next = (t_reg > rd_entry.start) ? (t_reg - rd_entry.start) : '0;
                end
                else
                begin
                    x_next = t_reg;
                end
            end
            ST_DELAY:
            begin
                x_next = x_reg - delay_x;
            end
            ST_ATTACK:
            begin
                x_next     = x_reg - attack_x;
                mul_a_next = hold_lvl_reg;
                mul_b_next = x_reg[TICK_W-1:0];
                den_next   = attack_reg;
            end
            ST_HOLD:
            begin
                x_next = x_reg - hold_x;
                if (x_reg < hold_x)
                begin
                    base_next = hold_lvl_reg;
                end
            end
            ST_DECAY:
            begin
                base_next  = sustain_lvl_reg;
                mul_b_next = decay_reg - x_reg[TICK_W-1:0];
                den_next   = decay_reg;
                if (hold_lvl_reg >= sustain_lvl_reg)
                begin
                    mul_a_next = hold_lvl_reg - sustain_lvl_reg;
                    sub_next   = 1'b0;
                end
                else
                begin
                    mul_a_next = sustain_lvl_reg - hold_lvl_reg;
                    sub_next   = 1'b1;
                end
            end
            ST_REL:
            begin
                mul_a_next = cap_reg;
                mul_b_next = release_reg - x_reg[TICK_W-1:0];
                den_next   = release_reg;
            end
            ST_MUL:
            begin
                num_next = prod;
            end
            ST_PREP:
            begin
                rem_next = num_reg[PROD_W-1:DIV_STEPS];
                cnt_next = '0;
            end
            ST_DIV:
            begin
                num_next = {num_reg[PROD_W-2:0], 1'b0};
                quo_next = {quo_reg[LVL_W-2:0], div_ge};
                rem_next = div_ge ? div_diff[TICK_W-1:0] : div_sh[TICK_W-1:0];
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_DONE:   ;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (done_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (env.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ram_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg       <= ch_next;
        key_up_reg   <= key_up_next;
        t_reg        <= t_next;
        in_range_reg <= in_range_next;
        rel_reg      <= rel_next;
        cap_reg      <= cap_next;
        x_reg        <= x_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        den_reg      <= den_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        base_reg     <= base_next;
        sub_reg      <= sub_next;
        if (done_fire)
        begin
            out_ch_reg  <= ch_reg;
            out_lvl_reg <= u_final ^ SIGN_FLIP;
        end
    end

    assign env.valid       = out_valid_reg;
    assign env.channel_out = out_ch_reg;
    assign env.level       = $signed(out_lvl_reg);

endmodule

FILE: rtl/core/dahdsr_checker.sv
// Port-level checks for the DAHDSR envelope generator, bound to the top level.
// Depends on dahdsr_pkg and dahdsr_envelope_generator.
`timescale 1ns / 1ps

module dahdsr_checker import dahdsr_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             psel,
    input logic             note_valid,
    input logic             note_ready,
    input logic             env_valid,
    input logic             env_ready,
    input logic [CH_W-1:0]  env_channel_out,
    input logic [LVL_W-1:0] env_level
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        env_valid && !env_ready |=> env_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        env_valid && !env_ready |=> $stable(env_channel_out) && $stable(env_level))
        else $error("stalled result changed");

    // no sample transaction during a register access
    assert property (@(posedge clk) disable iff (!rst_n)
        psel |-> !note_ready)
        else $error("input ready during register access");

    // one transaction in flight; no result in the cycle after an input is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        note_valid && note_ready |=> !note_ready)
        else $error("second input taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        note_valid && note_ready && !env_valid |=> !env_valid)
        else $error("result appeared too early");

endmodule

bind dahdsr_envelope_generator dahdsr_checker u_dahdsr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .note_valid      (note.valid),
    .note_ready      (note.ready),
    .env_valid       (env.valid),
    .env_ready       (env.ready),
    .env_channel_out (env.channel_out),
    .env_level       (env.level)
);
